@@ rtl/b64e_pkg.sv @@
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-character map of the Base64
// stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  // group queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  // alphabet anchors and padding
  localparam logic [7:0] CharUpperA = 8'h41;  // 'A'
  localparam logic [7:0] CharLowerA = 8'h61;  // 'a'
  localparam logic [7:0] CharDigit0 = 8'h30;  // '0'
  localparam logic [7:0] CharPlus   = 8'h2B;  // '+'
  localparam logic [7:0] CharSlash  = 8'h2F;  // '/'
  localparam logic [7:0] CharPad    = 8'h3D;  // '='

  localparam logic [5:0] SextetLower = 6'd26;
  localparam logic [5:0] SextetDigit = 6'd52;
  localparam logic [5:0] SextetPlus  = 6'd62;

  // one group of one to three bytes, left-aligned in 24 bits
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;  // 1..3
    logic        eom;
  } grp_t;

  // map a 6-bit value to its Base64 character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    priority if (v < SextetLower) begin
      c = CharUpperA + {2'b00, v};
    end else if (v < SextetDigit) begin
      c = CharLowerA + {2'b00, v - SextetLower};
    end else if (v < SextetPlus) begin
      c = CharDigit0 + {2'b00, v - SextetDigit};
    end else if (v == SextetPlus) begin
      c = CharPlus;
    end else begin
      c = CharSlash;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/b64e_front.sv @@
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, holds up to two pending bytes and pushes a full or
// end-of-message group into the group queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         end_of_message_i,
  input  wire logic         q_full_i,
  output logic              q_push_o,
  output b64e_pkg::grp_t    q_data_o
);
  import b64e_pkg::*;

  logic [7:0] pend_q [2];
  logic [1:0] count_q, count_d;
  logic       cnt_full;
  logic       need_push;
  logic       accept;

  // a held count of two (or the unreachable three) means a full group
  assign cnt_full   = count_q[1];
  assign need_push  = end_of_message_i | cnt_full;
  assign in_stall_o = q_full_i & need_push;
  assign accept     = in_valid_i & ~in_stall_o;
  assign q_push_o   = accept & need_push;

  // group assembly
  always_comb begin
    q_data_o.eom = end_of_message_i;
    unique case (count_q)
      2'd0: begin
        q_data_o.bits   = {data_byte_i, 16'h0000};
        q_data_o.nbytes = 2'd1;
      end
      2'd1: begin
        q_data_o.bits   = {pend_q[0], data_byte_i, 8'h00};
        q_data_o.nbytes = 2'd2;
      end
      default: begin
        q_data_o.bits   = {pend_q[0], pend_q[1], data_byte_i};
        q_data_o.nbytes = 2'd3;
      end
    endcase
  end

  // pending count
  always_comb begin
    count_d = count_q;
    if (accept) begin
      count_d = need_push ? 2'd0 : count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // pending byte store
  always_ff @(posedge clk_i) begin
    if (accept && !need_push) begin
      pend_q[count_q[0]] <= data_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/b64e_queue.sv @@
// ----------------------------------------------------------------------------
// b64e_queue
// Short first-in first-out queue of byte groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire b64e_pkg::grp_t  push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output b64e_pkg::grp_t       pop_data_o,
  output logic                 empty_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/b64e_back.sv @@
// ----------------------------------------------------------------------------
// b64e_back
// Takes groups from the queue and sends out four characters per group, one
// per cycle while out_stall_i is low, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire b64e_pkg::grp_t  q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [7:0]           out_char_o,
  output logic                 last_char_o
);
  import b64e_pkg::*;

  grp_t       grp_q;
  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  logic       oval_q, oval_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       adv, emit, last_emit;
  logic [5:0] sextet;

  // output register free or being taken this cycle
  assign adv       = ~oval_q | ~out_stall_i;
  assign emit      = busy_q & adv;
  assign last_emit = emit & (idx_q == 2'd3);
  assign q_pop_o   = ~q_empty_i & (~busy_q | last_emit);

  // sextet select for the current character
  always_comb begin
    unique case (idx_q)
      2'd0:    sextet = grp_q.bits[23:18];
      2'd1:    sextet = grp_q.bits[17:12];
      2'd2:    sextet = grp_q.bits[11:6];
      default: sextet = grp_q.bits[5:0];
    endcase
  end

  // sequencing and output register next state
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    oval_d = oval_q;
    char_d = char_q;
    last_d = last_q;
    if (adv) begin
      oval_d = emit;
    end
    if (emit) begin
      char_d = (idx_q > grp_q.nbytes) ? CharPad : sextet_char(sextet);
      last_d = last_emit & grp_q.eom;
      idx_d  = idx_q + 2'd1;
    end
    if (q_pop_o) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end else if (last_emit) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      oval_q <= oval_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    if (q_pop_o) begin
      grp_q <= q_data_i;
    end
  end

  assign out_valid_o = oval_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

@@ rtl/base64_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Byte stream in, Base64 (standard alphabet, '=' padded) character stream out.
//
// Input channel: in_valid_i / in_stall_o with data_byte_i and
// end_of_message_i. A transfer happens at an edge with valid high and stall
// low. Three bytes, or up to three ending in end_of_message, form a group.
// Output channel: out_valid_o / out_stall_i with out_char_o and last_char_o;
// each group yields four characters, last_char_o marks the fourth character
// of a message's final group.
// The first character of a group is taken from the queue entry into the
// group register and then into the output register. The back end sends one
// character per cycle while the receiver does not stall; input bytes are
// taken one per cycle until the group queue (QueueDepth groups) fills, and
// the sustained rate is set by the one-character output register, which
// sends four characters for every group.
// When the receiver stalls, the output holds, the queue fills and then only
// bytes that close a group are stalled. Reset empties the pending byte count,
// the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_message_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_char_o,
  output logic            last_char_o
);
  import b64e_pkg::*;

  grp_t push_data, pop_data;
  logic push, full, pop, empty;

  // byte intake and group assembly
  b64e_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .q_full_i         (full),
    .q_push_o         (push),
    .q_data_o         (push_data)
  );

  // group queue
  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // character output
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

`default_nettype wire
